// ===== src/ptcb_pkg.sv =====
// Shared types and constants for the pretrigger capture buffer.
// No dependencies; used by pretrigger_capture_buffer.
package ptcb_pkg;

	// Word and field widths
	localparam int SAMPLE_W = 32;
	localparam int KIND_W   = 2;
	localparam int POST_W   = 6;

	typedef logic [SAMPLE_W-1:0] sample_t;
	typedef logic [KIND_W-1:0]   kind_t;
	typedef logic [POST_W-1:0]   post_t;

	// Result kinds carried on m_tuser
	localparam kind_t KIND_HISTORY = 2'd0;
	localparam kind_t KIND_LIVE    = 2'd1;
	localparam kind_t KIND_PAD     = 2'd2;

	// post_count after reset
	localparam post_t POST_COUNT_RESET = 6'd16;

endpackage

// ===== src/pretrigger_capture_buffer.sv =====
// Pretrigger capture buffer: ring store of recent samples, dump on trigger,
// live pass-through and zero padding. Depends on ptcb_pkg.

// While buffering, one sample is taken every cycle and written into a ring of
// DEPTH words; no item comes out. A sample with its trigger flag set is stored
// and the whole ring is then sent out oldest first (kind history), ending with
// that sample; the ring is read through its single read port and the input is
// stalled meanwhile. Then post_count live samples (one if it is zero) pass
// straight through (kind live); the last of them is followed by post_count
// zero words (kind pad), during which the input is stalled. Dump, live and pad
// words each go out one per cycle when the output keeps up. Triggers seen
// during capture are ignored. After reset every ring slot reads as zero until
// written; per-slot valid bits cleared by reset make this so, with no clearing
// pass. m_tlast marks the final result caused by one input item.
module pretrigger_capture_buffer #(
	parameter int DEPTH = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// Configuration: post_count
	input  logic                      post_count_we,
	input  ptcb_pkg::post_t           post_count_wdata,
	// Input stream
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  ptcb_pkg::sample_t         s_tdata,   // [31:0] sample
	input  logic                      s_tuser,   // [0] trigger
	// Output stream
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output ptcb_pkg::sample_t         m_tdata,   // [31:0] data
	output ptcb_pkg::kind_t           m_tuser,   // [1:0] kind
	output logic                      m_tlast
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DUMP = 2'd1;
	localparam logic [1:0] ST_PAD  = 2'd2;

	localparam ptcb_pkg::post_t POST_ONE = 6'd1;

	// Ring store and per-slot valid bits
	ptcb_pkg::sample_t ring_mem [DEPTH];
	logic [DEPTH-1:0]  slot_vld_q;

	logic [1:0]             state_q;
	logic                   capturing_q;
	ptcb_pkg::post_t        post_count_q;
	ptcb_pkg::post_t        live_cnt_q;
	ptcb_pkg::post_t        pad_left_q;
	logic [AW-1:0]          wr_slot_q;
	logic [AW-1:0]          rd_addr_q;
	logic [CW-1:0]          rd_left_q;

	// Read stage
	logic                   s1_valid_q;
	logic                   s1_last_q;
	logic                   s1_slot_vld_s1;
	ptcb_pkg::sample_t      rdata_s1;

	// Output register
	logic                   out_valid_q;
	ptcb_pkg::sample_t      out_data_q;
	ptcb_pkg::kind_t        out_kind_q;
	logic                   out_last_q;

	logic                   out_free;
	logic                   in_acc;
	logic                   buf_wr;
	logic                   trig_acc;
	logic                   live_acc;
	logic                   rd_en;
	logic                   s1_move;
	logic                   pad_emit;
	logic [AW-1:0]          wr_slot_nxt;
	logic [AW-1:0]          rd_addr_nxt;
	ptcb_pkg::post_t        live_cnt_nxt;
	logic                   live_end;

	// Handshake and control decode
	assign out_free  = !out_valid_q || m_tready;
	assign s_tready  = (state_q == ST_IDLE) && (!capturing_q || out_free);
	assign in_acc    = s_tvalid && s_tready;
	assign buf_wr    = in_acc && !capturing_q;
	assign trig_acc  = buf_wr && s_tuser;
	assign live_acc  = in_acc && capturing_q;
	assign rd_en     = (state_q == ST_DUMP) && (rd_left_q != '0)
	                   && (!s1_valid_q || out_free);
	assign s1_move   = s1_valid_q && out_free;
	assign pad_emit  = (state_q == ST_PAD) && out_free;

	assign wr_slot_nxt  = (wr_slot_q == AW'(DEPTH - 1)) ? '0 : wr_slot_q + 1'b1;
	assign rd_addr_nxt  = (rd_addr_q == AW'(DEPTH - 1)) ? '0 : rd_addr_q + 1'b1;
	assign live_cnt_nxt = live_cnt_q + 1'b1;
	assign live_end     = live_cnt_nxt >= post_count_q;

	// Ring memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (buf_wr) begin
			ring_mem[wr_slot_q] <= s_tdata;
		end
		if (rd_en) begin
			rdata_s1 <= ring_mem[rd_addr_q];
		end
	end

	// Slot valid bits, sampled alongside the read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_vld_q     <= '0;
			s1_slot_vld_s1 <= 1'b0;
		end else begin
			if (buf_wr) begin
				slot_vld_q[wr_slot_q] <= 1'b1;
			end
			if (rd_en) begin
				s1_slot_vld_s1 <= slot_vld_q[rd_addr_q];
			end
		end
	end

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			post_count_q <= ptcb_pkg::POST_COUNT_RESET;
		end else if (post_count_we) begin
			post_count_q <= post_count_wdata;
		end
	end

	// Sequencer: buffering, live capture, ring dump, padding
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			capturing_q <= 1'b0;
			live_cnt_q  <= '0;
			pad_left_q  <= '0;
			wr_slot_q   <= '0;
			rd_addr_q   <= '0;
			rd_left_q   <= '0;
			s1_valid_q  <= 1'b0;
			s1_last_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (buf_wr) begin
						wr_slot_q <= wr_slot_nxt;
					end
					if (trig_acc) begin
						state_q     <= ST_DUMP;
						capturing_q <= 1'b1;
						live_cnt_q  <= '0;
						rd_addr_q   <= wr_slot_nxt;
						rd_left_q   <= CW'(DEPTH);
					end
					if (live_acc) begin
						if (live_end) begin
							capturing_q <= 1'b0;
							live_cnt_q  <= '0;
							if (post_count_q != '0) begin
								state_q    <= ST_PAD;
								pad_left_q <= post_count_q;
							end
						end else begin
							live_cnt_q <= live_cnt_nxt;
						end
					end
				end
				ST_DUMP: begin
					if (rd_en) begin
						rd_addr_q  <= rd_addr_nxt;
						rd_left_q  <= rd_left_q - 1'b1;
						s1_valid_q <= 1'b1;
						s1_last_q  <= (rd_left_q == CW'(1));
					end else if (s1_move) begin
						s1_valid_q <= 1'b0;
					end
					if ((rd_left_q == '0) && !s1_valid_q) begin
						state_q <= ST_IDLE;
					end
				end
				ST_PAD: begin
					if (pad_emit) begin
						pad_left_q <= pad_left_q - 1'b1;
						if (pad_left_q == POST_ONE) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output register: valid flag under reset, payload without
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_move || (live_acc) || pad_emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			out_data_q <= s1_slot_vld_s1 ? rdata_s1 : '0;
			out_kind_q <= ptcb_pkg::KIND_HISTORY;
			out_last_q <= s1_last_q;
		end else if (live_acc) begin
			out_data_q <= s_tdata;
			out_kind_q <= ptcb_pkg::KIND_LIVE;
			out_last_q <= !live_end || (post_count_q == '0);
		end else if (pad_emit) begin
			out_data_q <= '0;
			out_kind_q <= ptcb_pkg::KIND_PAD;
			out_last_q <= (pad_left_q == POST_ONE);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;

	// Checks
	a_trig_starts_dump: assert property (@(posedge clk) disable iff (!arst_n)
		trig_acc |=> (state_q == ST_DUMP) && capturing_q)
		else $error("trigger did not start a ring dump");

	a_s1_only_in_dump: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q |-> (state_q == ST_DUMP))
		else $error("read stage holds a word outside a dump");

	a_rd_left_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rd_left_q <= CW'(DEPTH))
		else $error("dump read count out of range");

	a_pad_left_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PAD) |-> (pad_left_q != '0) && !capturing_q)
		else $error("padding with no words left or while capturing");

	a_pad_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser == ptcb_pkg::KIND_PAD)) |-> (m_tdata == '0))
		else $error("pad word carries nonzero data");

endmodule
